### sv/ptp_port_state_machine_macros.svh
// Assertion macros shared by the port state machine modules
`ifndef PTP_PORT_STATE_MACHINE_MACROS_SVH
`define PTP_PORT_STATE_MACHINE_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold in the same cycle
`define PSM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define PSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define PSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/ptp_psm_pkg.sv
// Types, codes and the service enable table of the port state machine
package ptp_psm_pkg;

  localparam int CODE_W = 4;
  localparam int STEPS_W = 16;
  localparam int EN_W = 7;
  localparam int QUAL_W = 17;
  localparam int ERR_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [3:0] {
    ST_INIT         = 4'd0,
    ST_FAULTY       = 4'd1,
    ST_DISABLED     = 4'd2,
    ST_LISTENING    = 4'd3,
    ST_PRE_MASTER   = 4'd4,
    ST_MASTER       = 4'd5,
    ST_PASSIVE      = 4'd6,
    ST_UNCALIBRATED = 4'd7,
    ST_SLAVE        = 4'd8
  } state_t;

  // op field
  localparam logic OP_EVENT    = 1'b0;
  localparam logic OP_DECISION = 1'b1;

  // port events
  localparam logic [CODE_W-1:0] EV_POWERUP       = 4'd0;
  localparam logic [CODE_W-1:0] EV_INITIALIZE    = 4'd1;
  localparam logic [CODE_W-1:0] EV_INIT_DONE     = 4'd2;
  localparam logic [CODE_W-1:0] EV_FAULT_DET     = 4'd3;
  localparam logic [CODE_W-1:0] EV_FAULT_CLR     = 4'd4;
  localparam logic [CODE_W-1:0] EV_STATE_DEC     = 4'd5;
  localparam logic [CODE_W-1:0] EV_ANN_TMO       = 4'd6;
  localparam logic [CODE_W-1:0] EV_QUAL_TMO      = 4'd7;
  localparam logic [CODE_W-1:0] EV_MASTER_SEL    = 4'd8;
  localparam logic [CODE_W-1:0] EV_SYNC_FAULT    = 4'd9;
  localparam logic [CODE_W-1:0] EV_DESIG_ENABLE  = 4'd10;
  localparam logic [CODE_W-1:0] EV_DESIG_DISABLE = 4'd11;

  // recommended state decisions
  localparam logic [CODE_W-1:0] DEC_LIST = 4'd0;
  localparam logic [CODE_W-1:0] DEC_M1   = 4'd1;
  localparam logic [CODE_W-1:0] DEC_M2   = 4'd2;
  localparam logic [CODE_W-1:0] DEC_M3   = 4'd3;
  localparam logic [CODE_W-1:0] DEC_P1   = 4'd4;
  localparam logic [CODE_W-1:0] DEC_P2   = 4'd5;
  localparam logic [CODE_W-1:0] DEC_S1   = 4'd6;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_INIT_DONE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LIST      = 2'd2;

  localparam logic [1:0] CT_ORDINARY    = 2'd0;
  localparam logic [1:0] CT_BOUNDARY    = 2'd1;
  localparam logic [1:0] CT_TRANSPARENT = 2'd2;

  localparam logic [1:0] DM_E2E      = 2'd0;
  localparam logic [1:0] DM_P2P      = 2'd1;
  localparam logic [1:0] DM_DISABLED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PORT_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ONLY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_TYPE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TC_E2E_REQ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MECH   = 3'd4;

  // service enable bits
  localparam logic [EN_W-1:0] EN_SYNC_INT = 7'h01;
  localparam logic [EN_W-1:0] EN_SYNC_TMO = 7'h02;
  localparam logic [EN_W-1:0] EN_SYNC_LSN = 7'h04;
  localparam logic [EN_W-1:0] EN_ANN_LSN  = 7'h08;
  localparam logic [EN_W-1:0] EN_ANN_INT  = 7'h10;
  localparam logic [EN_W-1:0] EN_DELAY    = 7'h20;
  localparam logic [EN_W-1:0] EN_PDELAY   = 7'h40;

  typedef struct packed {
    logic       port_enabled;
    logic       slave_only;
    logic [1:0] clock_type;
    logic       tc_e2e_req;
    logic [1:0] delay_mechanism;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [CODE_W-1:0]  code;
    logic               new_master;
    logic [STEPS_W-1:0] steps_removed;
    logic               grandmaster_is_self;
  } item_t;

  typedef struct packed {
    state_t             port_state;
    logic               state_changed;
    logic [EN_W-1:0]    service_enables;
    logic               qual_timeout_valid;
    logic [QUAL_W-1:0]  qual_timeout_intervals;
    logic               init_request;
    logic [ERR_W-1:0]   error_code;
  } res_t;

  function automatic logic [EN_W-1:0] enables_for(state_t st, cfg_t cfg);
    logic [EN_W-1:0] pd;
    logic [EN_W-1:0] en;
    pd = (cfg.delay_mechanism == DM_P2P) ? EN_PDELAY : '0;
    case (st)
      ST_LISTENING, ST_PASSIVE: en = EN_ANN_LSN | pd;
      ST_PRE_MASTER:            en = EN_SYNC_TMO | pd;
      ST_MASTER:                en = EN_SYNC_INT | EN_ANN_INT | pd;
      ST_UNCALIBRATED, ST_SLAVE: begin
        en = EN_SYNC_LSN | EN_ANN_LSN | pd;
        if (cfg.delay_mechanism == DM_E2E &&
            (cfg.clock_type == CT_ORDINARY ||
             (cfg.clock_type == CT_TRANSPARENT && cfg.tc_e2e_req))) begin
          en = en | EN_DELAY;
        end
      end
      default: en = '0;
    endcase
    return en;
  endfunction

endpackage

### sv/ptp_psm_in_stage.sv
// Input register stage of the port state machine
module ptp_psm_in_stage
  import ptp_psm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  adv,
  output logic  item_vld,
  output item_t item
);

  logic  vld_r, vld_nxt;
  item_t item_r;

  assign in_ready = !vld_r || adv;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

### sv/ptp_psm_fsm.sv
// Port state register, next-state decode and service enable update
`include "ptp_port_state_machine_macros.svh"
module ptp_psm_fsm
  import ptp_psm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  item_t item,
  input  logic  adv,
  output res_t  res
);

  state_t            state_r, state_nxt;
  logic [EN_W-1:0]   en_r, en_nxt;
  logic [QUAL_W-1:0] qual_r, qual_nxt;
  logic              qvalid, initreq, changed;
  logic [ERR_W-1:0]  err;
  logic              oper, no_master, ann_to_list;

  assign oper        = state_r inside {[ST_LISTENING:ST_SLAVE]};
  assign no_master   = cfg.slave_only ||
                       (cfg.clock_type == CT_TRANSPARENT && item.code == DEC_M3);
  assign ann_to_list = cfg.slave_only ||
                       (cfg.clock_type == CT_TRANSPARENT && !item.grandmaster_is_self);

  // next state
  always_comb begin
    state_nxt = state_r;
    qual_nxt  = qual_r;
    qvalid    = 1'b0;
    initreq   = 1'b0;
    err       = ERR_NONE;
    if (item.op == OP_EVENT) begin
      case (item.code)
        EV_POWERUP, EV_INITIALIZE: state_nxt = ST_INIT;
        EV_INIT_DONE: begin
          if (state_r != ST_INIT) begin
            err = ERR_INIT_DONE;
          end else begin
            state_nxt = cfg.port_enabled ? ST_LISTENING : ST_DISABLED;
          end
        end
        EV_FAULT_DET: begin
          if (oper || state_r == ST_FAULTY) state_nxt = ST_FAULTY;
        end
        EV_FAULT_CLR: begin
          if (state_r == ST_FAULTY) initreq = 1'b1;
        end
        EV_ANN_TMO: begin
          if (state_r inside {ST_LISTENING, ST_UNCALIBRATED, ST_SLAVE}) begin
            state_nxt = ann_to_list ? ST_LISTENING : ST_MASTER;
          end else if (state_r == ST_PASSIVE) begin
            state_nxt = ST_MASTER;
          end
        end
        EV_QUAL_TMO: begin
          if (state_r == ST_PRE_MASTER) state_nxt = ST_MASTER;
        end
        EV_MASTER_SEL: begin
          if (state_r == ST_UNCALIBRATED) state_nxt = ST_SLAVE;
        end
        EV_SYNC_FAULT: begin
          if (state_r == ST_SLAVE) state_nxt = ST_UNCALIBRATED;
        end
        EV_DESIG_ENABLE: begin
          if (state_r == ST_DISABLED) state_nxt = ST_INIT;
        end
        EV_DESIG_DISABLE: begin
          if (oper || state_r == ST_FAULTY) state_nxt = ST_DISABLED;
        end
        default: ;
      endcase
    end else if (oper) begin
      case (item.code)
        DEC_LIST: begin
          if (state_r != ST_LISTENING) err = ERR_LIST;
        end
        DEC_M1, DEC_M2, DEC_M3: begin
          qvalid   = 1'b1;
          qual_nxt = (item.code == DEC_M3) ?
                     QUAL_W'(item.steps_removed) + QUAL_W'(1) : '0;
          if (state_r == ST_MASTER) begin
            state_nxt = no_master ? ST_PASSIVE : ST_MASTER;
          end else begin
            state_nxt = no_master ? ST_LISTENING : ST_PRE_MASTER;
          end
        end
        DEC_P1, DEC_P2: state_nxt = ST_PASSIVE;
        DEC_S1: begin
          if (state_r != ST_SLAVE || item.new_master) state_nxt = ST_UNCALIBRATED;
        end
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    changed = (state_nxt != state_r);
    en_nxt  = changed ? enables_for(state_nxt, cfg) : en_r;
    res.port_state             = state_nxt;
    res.state_changed          = changed;
    res.service_enables        = en_nxt;
    res.qual_timeout_valid     = qvalid;
    res.qual_timeout_intervals = qual_nxt;
    res.init_request           = initreq;
    res.error_code             = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      en_r    <= '0;
      qual_r  <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
      en_r    <= en_nxt;
      qual_r  <= qual_nxt;
    end
  end

  `PSM_ASSERT(a_init_req_faulty, clk, rst_n, !res.init_request || state_r == ST_FAULTY, "init request outside faulty")
  `PSM_ASSERT(a_err_no_move, clk, rst_n, res.error_code == ERR_NONE || !res.state_changed, "error with state change")
  `PSM_ASSERT_NEXT(a_hold_no_change, clk, rst_n, adv && !res.state_changed, $stable(state_r) && $stable(en_r), "state moved without change flag")
  `PSM_ASSERT_NEXT(a_en_follow, clk, rst_n, adv && res.state_changed, en_r == enables_for(state_r, cfg), "enables do not match new state")

endmodule

### sv/ptp_port_state_machine.sv
// Top level of the port state machine: config registers, stages, result register
//
//   channel  | handshake            | transaction payload
//   ---------+----------------------+----------------------------------------------
//   in_      | in_valid / in_ready  | op, code, new_master, steps_removed, gm self
//   out_     | out_valid/out_ready  | state, changed, enables, qual timeout, init request, errors
//   cfg_     | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready is high; each goes through
// the input register, then the result register. The next-state decode between
// them reads the port state register and updates it as the result register loads.
// A stalled result holds; the input register keeps taking transactions while
// the result register drains. Reset is synchronous: state INIT, enables off.
`include "ptp_port_state_machine_macros.svh"
module ptp_port_state_machine
  import ptp_psm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_op,
  input  logic [CODE_W-1:0]      in_code,
  input  logic                   in_new_master,
  input  logic [STEPS_W-1:0]     in_steps_removed,
  input  logic                   in_grandmaster_is_self,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             out_port_state,
  output logic                   out_state_changed,
  output logic [EN_W-1:0]        out_service_enables,
  output logic                   out_qual_timeout_valid,
  output logic [QUAL_W-1:0]      out_qual_timeout_intervals,
  output logic                   out_init_request,
  output logic [ERR_W-1:0]       out_error_code
);

  cfg_t  cfg_r;
  item_t in_item, item;
  logic  item_vld, adv;
  res_t  res, res_r;
  logic  out_vld_r, out_vld_nxt;
  logic  qual_st_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.port_enabled    <= 1'b1;
      cfg_r.slave_only      <= 1'b0;
      cfg_r.clock_type      <= CT_ORDINARY;
      cfg_r.tc_e2e_req      <= 1'b0;
      cfg_r.delay_mechanism <= DM_E2E;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PORT_ENABLED: cfg_r.port_enabled    <= cfg_data[0];
        CFG_SLAVE_ONLY:   cfg_r.slave_only      <= cfg_data[0];
        CFG_CLOCK_TYPE:   cfg_r.clock_type      <= cfg_data;
        CFG_TC_E2E_REQ:   cfg_r.tc_e2e_req      <= cfg_data[0];
        CFG_DELAY_MECH:   cfg_r.delay_mechanism <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.op                  = in_op;
  assign in_item.code                = in_code;
  assign in_item.new_master          = in_new_master;
  assign in_item.steps_removed       = in_steps_removed;
  assign in_item.grandmaster_is_self = in_grandmaster_is_self;

  assign adv = item_vld && (!out_vld_r || out_ready);

  ptp_psm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .adv      (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  ptp_psm_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .item  (item),
    .adv   (adv),
    .res   (res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid                  = out_vld_r;
  assign out_port_state             = res_r.port_state;
  assign out_state_changed          = res_r.state_changed;
  assign out_service_enables        = res_r.service_enables;
  assign out_qual_timeout_valid     = res_r.qual_timeout_valid;
  assign out_qual_timeout_intervals = res_r.qual_timeout_intervals;
  assign out_init_request           = res_r.init_request;
  assign out_error_code             = res_r.error_code;

  assign qual_st_ok = out_port_state inside {ST_LISTENING, ST_PRE_MASTER, ST_MASTER, ST_PASSIVE};

  `PSM_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, adv, out_valid, "advanced transaction lost")
  `PSM_ASSERT_NEXT(a_drain_empties, clk, rst_n, out_valid && out_ready && !adv, !out_valid, "result repeated")
  `PSM_ASSERT(a_qual_operational, clk, rst_n, !(out_valid && out_qual_timeout_valid) || qual_st_ok, "qual timeout in wrong state")

endmodule

### sim/ptp_port_state_machine_checker.sv
// Checker for the port state machine: predicts each report and compares it
module ptp_port_state_machine_checker
  import ptp_psm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_op,
  input  logic [CODE_W-1:0]     in_code,
  input  logic                  in_new_master,
  input  logic [STEPS_W-1:0]    in_steps_removed,
  input  logic                  in_grandmaster_is_self,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [3:0]            out_port_state,
  input  logic                  out_state_changed,
  input  logic [EN_W-1:0]       out_service_enables,
  input  logic                  out_qual_timeout_valid,
  input  logic [QUAL_W-1:0]     out_qual_timeout_intervals,
  input  logic                  out_init_request,
  input  logic [ERR_W-1:0]      out_error_code,
  output int                    mismatch_count,
  output int                    reports_pending,
  output int                    transactions_in,
  output int                    reports_checked,
  output logic [8:0]            states_seen
);

  cfg_t            port_cfg;
  state_t          port_st;
  logic [EN_W-1:0] enables_q;
  logic [QUAL_W-1:0] qual_q;
  res_t            pending_reports[$];

  function automatic logic enter_state(state_t nxt);
    logic [EN_W-1:0] pd;
    logic [EN_W-1:0] svc;
    if (nxt == port_st) return 1'b0;
    pd = (port_cfg.delay_mechanism == DM_P2P) ? EN_PDELAY : '0;
    case (nxt)
      ST_LISTENING, ST_PASSIVE: svc = EN_ANN_LSN | pd;
      ST_PRE_MASTER: svc = EN_SYNC_TMO | pd;
      ST_MASTER: svc = EN_SYNC_INT | EN_ANN_INT | pd;
      ST_UNCALIBRATED, ST_SLAVE: begin
        svc = EN_SYNC_LSN | EN_ANN_LSN | pd;
        if (port_cfg.delay_mechanism == DM_E2E &&
            (port_cfg.clock_type == CT_ORDINARY ||
             (port_cfg.clock_type == CT_TRANSPARENT && port_cfg.tc_e2e_req)))
          svc = svc | EN_DELAY;
      end
      default: svc = '0;
    endcase
    enables_q = svc;
    port_st = nxt;
    return 1'b1;
  endfunction

  function automatic res_t predict_port_report(item_t it);
    res_t r;
    logic chg;
    logic oper;
    logic no_master;
    r = '0;
    chg = 1'b0;
    oper = (port_st >= ST_LISTENING) && (port_st <= ST_SLAVE);
    if (it.op == OP_EVENT) begin
      case (it.code)
        EV_POWERUP, EV_INITIALIZE: chg = enter_state(ST_INIT);
        EV_INIT_DONE: begin
          if (port_st != ST_INIT) r.error_code = ERR_INIT_DONE;
          else chg = enter_state(port_cfg.port_enabled ? ST_LISTENING : ST_DISABLED);
        end
        EV_FAULT_DET: begin
          if (oper || port_st == ST_FAULTY) chg = enter_state(ST_FAULTY);
        end
        EV_FAULT_CLR: r.init_request = (port_st == ST_FAULTY);
        EV_ANN_TMO: begin
          if (port_st == ST_LISTENING || port_st == ST_UNCALIBRATED ||
              port_st == ST_SLAVE) begin
            if (port_cfg.slave_only ||
                (port_cfg.clock_type == CT_TRANSPARENT && !it.grandmaster_is_self))
              chg = enter_state(ST_LISTENING);
            else
              chg = enter_state(ST_MASTER);
          end else if (port_st == ST_PASSIVE) begin
            chg = enter_state(ST_MASTER);
          end
        end
        EV_QUAL_TMO: if (port_st == ST_PRE_MASTER) chg = enter_state(ST_MASTER);
        EV_MASTER_SEL: if (port_st == ST_UNCALIBRATED) chg = enter_state(ST_SLAVE);
        EV_SYNC_FAULT: if (port_st == ST_SLAVE) chg = enter_state(ST_UNCALIBRATED);
        EV_DESIG_ENABLE: if (port_st == ST_DISABLED) chg = enter_state(ST_INIT);
        EV_DESIG_DISABLE: begin
          if (oper || port_st == ST_FAULTY) chg = enter_state(ST_DISABLED);
        end
        default: ;
      endcase
    end else if (oper && it.code <= DEC_S1) begin
      no_master = port_cfg.slave_only ||
                  (port_cfg.clock_type == CT_TRANSPARENT && it.code == DEC_M3);
      case (it.code)
        DEC_LIST: if (port_st != ST_LISTENING) r.error_code = ERR_LIST;
        DEC_M1, DEC_M2, DEC_M3: begin
          r.qual_timeout_valid = 1'b1;
          qual_q = (it.code == DEC_M3) ? {1'b0, it.steps_removed} + 17'd1 : '0;
          if (port_st == ST_MASTER) chg = enter_state(no_master ? ST_PASSIVE : ST_MASTER);
          else chg = enter_state(no_master ? ST_LISTENING : ST_PRE_MASTER);
        end
        DEC_P1, DEC_P2: chg = enter_state(ST_PASSIVE);
        default: begin
          if (port_st != ST_SLAVE || it.new_master) chg = enter_state(ST_UNCALIBRATED);
        end
      endcase
    end
    r.port_state = port_st;
    r.state_changed = chg;
    r.service_enables = enables_q;
    r.qual_timeout_intervals = qual_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [QUAL_W-1:0] exp_v,
                             input logic [QUAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t exp_r;
    item_t it;
    if (!rst_n) begin
      port_cfg = {1'b1, 1'b0, CT_ORDINARY, 1'b0, DM_E2E};
      port_st = ST_INIT;
      enables_q = '0;
      qual_q = '0;
      pending_reports.delete();
      mismatch_count = 0;
      transactions_in = 0;
      reports_checked = 0;
      states_seen = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PORT_ENABLED: port_cfg.port_enabled = cfg_data[0];
          CFG_SLAVE_ONLY:   port_cfg.slave_only = cfg_data[0];
          CFG_CLOCK_TYPE:   port_cfg.clock_type = cfg_data;
          CFG_TC_E2E_REQ:   port_cfg.tc_e2e_req = cfg_data[0];
          CFG_DELAY_MECH:   port_cfg.delay_mechanism = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        it = {in_op, in_code, in_new_master, in_steps_removed, in_grandmaster_is_self};
        pending_reports.push_back(predict_port_report(it));
        transactions_in++;
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: report with none expected: state %0d", $time, out_port_state);
        end else begin
          exp_r = pending_reports.pop_front();
          check_field("port_state", QUAL_W'(exp_r.port_state), QUAL_W'(out_port_state));
          check_field("state_changed", QUAL_W'(exp_r.state_changed),
                      QUAL_W'(out_state_changed));
          check_field("service_enables", QUAL_W'(exp_r.service_enables),
                      QUAL_W'(out_service_enables));
          check_field("qual_timeout_valid", QUAL_W'(exp_r.qual_timeout_valid),
                      QUAL_W'(out_qual_timeout_valid));
          check_field("qual_timeout_intervals", exp_r.qual_timeout_intervals,
                      out_qual_timeout_intervals);
          check_field("init_request", QUAL_W'(exp_r.init_request), QUAL_W'(out_init_request));
          check_field("error_code", QUAL_W'(exp_r.error_code), QUAL_W'(out_error_code));
          states_seen[exp_r.port_state] = 1'b1;
          reports_checked++;
        end
      end
    end
    reports_pending = pending_reports.size();
  end

endmodule

### sim/ptp_port_state_machine_tb.sv
// Testbench top for the port state machine: stimulus, config phases and verdict
module ptp_port_state_machine_tb;
  import ptp_psm_pkg::*;

  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 154;
  localparam int STALL_LIMIT = 2000;
  localparam logic [CODE_W-1:0] CODE_UNKNOWN = 4'd15;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_op = 1'b0;
  logic [CODE_W-1:0]     in_code = '0;
  logic                  in_new_master = 1'b0;
  logic [STEPS_W-1:0]    in_steps_removed = '0;
  logic                  in_grandmaster_is_self = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [3:0]            out_port_state;
  logic                  out_state_changed;
  logic [EN_W-1:0]       out_service_enables;
  logic                  out_qual_timeout_valid;
  logic [QUAL_W-1:0]     out_qual_timeout_intervals;
  logic                  out_init_request;
  logic [ERR_W-1:0]      out_error_code;

  int         mismatch_count;
  int         reports_pending;
  int         transactions_in;
  int         reports_checked;
  logic [8:0] states_seen;
  logic       idle_on = 1'b1;
  int         quiet_cycles = 0;

  ptp_port_state_machine DUT (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_op, .in_code, .in_new_master, .in_steps_removed,
    .in_grandmaster_is_self,
    .out_valid, .out_ready, .out_port_state, .out_state_changed, .out_service_enables,
    .out_qual_timeout_valid, .out_qual_timeout_intervals, .out_init_request, .out_error_code
  );

  ptp_port_state_machine_checker checker_i (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_op, .in_code, .in_new_master, .in_steps_removed,
    .in_grandmaster_is_self,
    .out_valid, .out_ready, .out_port_state, .out_state_changed, .out_service_enables,
    .out_qual_timeout_valid, .out_qual_timeout_intervals, .out_init_request, .out_error_code,
    .mismatch_count, .reports_pending, .transactions_in, .reports_checked, .states_seen
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= 9) : 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer_port_input(input logic op, input logic [CODE_W-1:0] code,
                                  input logic nm, input logic [STEPS_W-1:0] steps,
                                  input logic gm);
    if (idle_on && $urandom_range(99) < 9) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_code <= code;
    in_new_master <= nm;
    in_steps_removed <= steps;
    in_grandmaster_is_self <= gm;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle_port();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  initial begin : stimulus
    cfg_t             s;
    int               r;
    logic             op;
    logic [CODE_W-1:0] code;
    logic [STEPS_W-1:0] steps;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // walk the main states under the reset settings
    offer_port_input(OP_DECISION, DEC_M1, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, EV_INIT_DONE, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, EV_INIT_DONE, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_DECISION, DEC_LIST, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, CODE_UNKNOWN, 1'b1, 16'hFFFF, 1'b1);
    offer_port_input(OP_EVENT, EV_STATE_DEC, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_DECISION, CODE_UNKNOWN, 1'b1, 16'hFFFF, 1'b1);
    offer_port_input(OP_DECISION, DEC_M3, 1'b0, 16'hFFFF, 1'b0);
    offer_port_input(OP_DECISION, DEC_LIST, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, EV_QUAL_TMO, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_DECISION, DEC_M2, 1'b0, 16'h1234, 1'b0);
    offer_port_input(OP_DECISION, DEC_P1, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, EV_ANN_TMO, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_DECISION, DEC_P2, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_DECISION, DEC_S1, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, EV_MASTER_SEL, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_DECISION, DEC_S1, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_DECISION, DEC_S1, 1'b1, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, EV_MASTER_SEL, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, EV_SYNC_FAULT, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, EV_ANN_TMO, 1'b0, 16'd0, 1'b1);
    offer_port_input(OP_EVENT, EV_FAULT_DET, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, EV_FAULT_CLR, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, EV_DESIG_DISABLE, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, EV_DESIG_ENABLE, 1'b0, 16'd0, 1'b0);
    offer_port_input(OP_EVENT, EV_POWERUP, 1'b0, 16'd0, 1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_port();
      case (ph)
        0: s = {1'b1, 1'b0, CT_ORDINARY, 1'b0, DM_E2E};
        1: s = {1'b1, 1'b1, 2'b11, 1'b1, 2'b11};
        2: s = {1'b0, 1'b0, CT_ORDINARY, 1'b0, DM_E2E};
        3: s = {1'b1, 1'b0, CT_TRANSPARENT, 1'b1, DM_E2E};
        4: s = {1'b1, 1'b0, CT_BOUNDARY, 1'b0, DM_P2P};
        default: begin
          s.port_enabled = ($urandom_range(3) != 0);
          s.slave_only = 1'($urandom_range(1));
          s.clock_type = 2'($urandom_range(3));
          s.tc_e2e_req = 1'($urandom_range(1));
          s.delay_mechanism = 2'($urandom_range(3));
        end
      endcase
      write_setting(CFG_PORT_ENABLED, {1'($urandom_range(1)), s.port_enabled});
      write_setting(CFG_SLAVE_ONLY, {1'($urandom_range(1)), s.slave_only});
      write_setting(CFG_CLOCK_TYPE, s.clock_type);
      write_setting(CFG_TC_E2E_REQ, {1'($urandom_range(1)), s.tc_e2e_req});
      write_setting(CFG_DELAY_MECH, s.delay_mechanism);
      write_setting(CFG_UNUSED, 2'($urandom_range(3)));
      @(negedge clk);
      cfg_we <= 1'b0;
      idle_on = (ph != 3);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) settle_port();
        r = $urandom_range(99);
        op = OP_EVENT;
        if (r < 5) begin
          op = 1'($urandom_range(1));
          code = CODE_W'($urandom_range(15));
        end else if (r < 12) begin
          case ($urandom_range(5))
            0: code = EV_POWERUP;
            1: code = EV_INITIALIZE;
            2: code = EV_FAULT_DET;
            3: code = EV_FAULT_CLR;
            4: code = EV_DESIG_DISABLE;
            default: code = EV_DESIG_ENABLE;
          endcase
        end else if (r < 24) begin
          code = EV_INIT_DONE;
        end else if (r < 62) begin
          op = OP_DECISION;
          code = CODE_W'($urandom_range(DEC_S1));
        end else begin
          case ($urandom_range(4))
            0: code = EV_ANN_TMO;
            1: code = EV_QUAL_TMO;
            2: code = EV_MASTER_SEL;
            3: code = EV_SYNC_FAULT;
            default: code = EV_DESIG_ENABLE;
          endcase
        end
        case ($urandom_range(3))
          0: steps = '0;
          1: steps = '1;
          default: steps = STEPS_W'($urandom_range(16'hFFFF));
        endcase
        offer_port_input(op, code, 1'($urandom_range(1)), steps, 1'($urandom_range(1)));
      end
    end

    settle_port();
    repeat (8) @(negedge clk);
    $display("Summary: %0d port transactions sent, %0d reports checked over %0d settings",
             transactions_in, reports_checked, NUM_PHASES + 1);
    $display("Summary: port states reached (bit per state, slave first) %b", states_seen);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
